/* sv/mfbp_pkg.sv */
// Shared types and constants for the MSB-first bit packer.
// Used by mfbp_ctrl, mfbp_dp and msb_first_bit_packer_unit; no dependencies.
`timescale 1ns / 1ps

package mfbp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned WIDTH_W = 7;   // packing width register and bit counter
  localparam int unsigned FREE_W  = 4;   // free bit count, 1 to 8

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 7'd8;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX   = 7'd64;
  localparam logic [FREE_W-1:0]  FREE_FULL   = 4'd8;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture a request and align its value
    logic step;   // move up to one byte of bits
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic final_step;  // the current step finishes the request
    logic out_free;    // output register can take a byte this cycle
    logic empty;       // no pending bits in the partial byte
  } sts_t;

endpackage

/* sv/msb_first_bit_packer_unit.sv */
// MSB-first bit packer: streams values, each cut to the packing width,
// into contiguous bytes filled from bit 7 down.
// Channels: in_* takes one 64-bit value per request (in_tlast ends a list);
// out_* gives one packed byte per transfer (out_tlast on a list's final byte).
// cfg_wr_en/cfg_wr_data set the packing width (0 acts as 1, above 64 acts
// as 64); write it only while no request is in flight.
// Flow: a request is taken while the block is idle; then the datapath moves
// at most one byte per cycle through the single output register while the
// receiver takes them, one step for each output byte the request touches,
// and the input stays busy until the final step. A byte enters the output
// register at the step that completes it; the first step follows the load.
// Each step waits while the output register holds a byte not yet taken.
// When the receiver stalls, the held byte stays in the output register and
// packing pauses; the next request may be taken while the final byte of the
// previous one still waits.
// Reset (rst_n low, synchronous) empties the partial byte, sets the packing
// width to 8 and drops out_tvalid.
`timescale 1ns / 1ps

module msb_first_bit_packer_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [6:0] cfg_wr_data,   // pack_width
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [63:0] in_tdata,     // [63:0] value
  input  logic       in_tlast,      // last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,     // [7:0] out_byte
  output logic       out_tlast      // last_byte
);
  import mfbp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mfbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mfbp_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_value    (in_tdata),
    .in_last     (in_tlast),
    .out_byte    (out_tdata),
    .out_last    (out_tlast),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready)
  );

  // A taken request leaves the input busy in the next cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after a request was taken");

  // Load and step never issue together
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.step}))
    else $error("load and step issued in the same cycle");

  // While a list's final byte waits and the block is idle, nothing is pending
  a_flush_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && in_tready |-> sts.empty)
    else $error("partial byte not cleared after a list ended");

endmodule

/* sv/mfbp_ctrl.sv */
// Controller of the MSB-first bit packer: idle/run state machine.
// Depends on mfbp_pkg for the command and status structs.
`timescale 1ns / 1ps

module mfbp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           req_valid,
  output logic           req_ready,
  input  mfbp_pkg::sts_t sts,
  output mfbp_pkg::cmd_t cmd
);
  import mfbp_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_r;
  logic state_nxt;

  // Take a request when idle, then step once per free output slot
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    req_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts.out_free) begin
          cmd.step = 1'b1;
          if (sts.final_step) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* sv/mfbp_dp.sv */
// Datapath of the MSB-first bit packer: width register, aligned value,
// partial byte, free bit count and output register. Depends on mfbp_pkg.
`timescale 1ns / 1ps

module mfbp_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mfbp_pkg::cmd_t                cmd,
  output mfbp_pkg::sts_t                sts,
  input  logic                          cfg_wr_en,
  input  logic [mfbp_pkg::WIDTH_W-1:0]  cfg_wr_data,
  input  logic [mfbp_pkg::VALUE_W-1:0]  in_value,
  input  logic                          in_last,
  output logic [mfbp_pkg::BYTE_W-1:0]   out_byte,
  output logic                          out_last,
  output logic                          out_valid,
  input  logic                          out_ready
);
  import mfbp_pkg::*;

  logic [WIDTH_W-1:0] width_r;
  logic [WIDTH_W-1:0] eff_width;
  logic [5:0]         align_sh;

  logic [VALUE_W-1:0] val_r,     val_nxt;
  logic [WIDTH_W-1:0] bits_r,    bits_nxt;
  logic               last_r,    last_nxt;
  logic [BYTE_W-1:0]  partial_r, partial_nxt;
  logic [FREE_W-1:0]  free_r,    free_nxt;
  logic [BYTE_W-1:0]  obyte_r,   obyte_nxt;
  logic               olast_r,   olast_nxt;
  logic               ovalid_r,  ovalid_nxt;

  logic [WIDTH_W-1:0] free_ext;
  logic [2:0]         top_sh;
  logic [BYTE_W-1:0]  merged;
  logic               full_byte;

  // Clamp the configured width to 1..64
  always_comb begin
    if (width_r == '0) begin
      eff_width = 7'd1;
    end else if (width_r > WIDTH_MAX) begin
      eff_width = WIDTH_MAX;
    end else begin
      eff_width = width_r;
    end
  end

  // Left-align the value so its top packed bit sits at bit 63
  assign align_sh = 6'(WIDTH_MAX - eff_width);

  // Merge the top bits of the aligned value into the free positions
  assign free_ext  = {3'b000, free_r};
  assign top_sh    = 3'(FREE_FULL - free_r);
  assign merged    = partial_r | (val_r[VALUE_W-1 -: BYTE_W] >> top_sh);
  assign full_byte = (bits_r >= free_ext);

  assign sts.final_step = (bits_r <= free_ext);
  assign sts.out_free   = !ovalid_r || out_ready;
  assign sts.empty      = (free_r == FREE_FULL) && (partial_r == '0);

  always_comb begin
    val_nxt     = val_r;
    bits_nxt    = bits_r;
    last_nxt    = last_r;
    partial_nxt = partial_r;
    free_nxt    = free_r;
    obyte_nxt   = obyte_r;
    olast_nxt   = olast_r;
    ovalid_nxt  = ovalid_r && !out_ready;

    if (cmd.load) begin
      // Capture the request; high bits beyond the width drop off the top
      val_nxt  = in_value << align_sh;
      bits_nxt = eff_width;
      last_nxt = in_last;
    end else if (cmd.step) begin
      if (full_byte) begin
        // Complete a byte and emit it
        obyte_nxt   = merged;
        olast_nxt   = last_r && (bits_r == free_ext);
        ovalid_nxt  = 1'b1;
        val_nxt     = val_r << free_r;
        bits_nxt    = bits_r - free_ext;
        partial_nxt = '0;
        free_nxt    = FREE_FULL;
      end else begin
        // Absorb the remaining bits; flush on the final request of a list
        partial_nxt = merged;
        free_nxt    = free_r - bits_r[FREE_W-1:0];
        bits_nxt    = '0;
        if (last_r) begin
          obyte_nxt   = merged;
          olast_nxt   = 1'b1;
          ovalid_nxt  = 1'b1;
          partial_nxt = '0;
          free_nxt    = FREE_FULL;
        end
      end
    end
  end

  // Control and packing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= WIDTH_RESET;
      partial_r <= '0;
      free_r    <= FREE_FULL;
      ovalid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        width_r <= cfg_wr_data;
      end
      partial_r <= partial_nxt;
      free_r    <= free_nxt;
      ovalid_r  <= ovalid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    val_r   <= val_nxt;
    bits_r  <= bits_nxt;
    last_r  <= last_nxt;
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
  end

  assign out_byte  = obyte_r;
  assign out_last  = olast_r;
  assign out_valid = ovalid_r;

endmodule

/* sim/tb_msb_first_bit_packer_unit.sv */
// Self-checking bench for msb_first_bit_packer_unit: predicts every packed byte
// per request through a small scoreboard class. Depends on mfbp_pkg and the block.
`timescale 1ns / 1ps

module tb_msb_first_bit_packer_unit;
  import mfbp_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 24;      // block latency plus margin
  localparam int unsigned LONG_HOLD     = 400;     // receiver hold-off, cycles
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned PHASE_ITEMS   = 42;
  localparam int unsigned PHASE_COUNT   = 12;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } packed_byte_t;

  // Predict packed bytes and check them in order
  class packer_scoreboard;
    logic [WIDTH_W-1:0] width_reg;
    logic [BYTE_W-1:0]  partial;
    logic [FREE_W-1:0]  free_cnt;
    packed_byte_t       pending[$];
    int                 errors;

    function new();
      width_reg = WIDTH_RESET;
      partial   = '0;
      free_cnt  = FREE_FULL;
      errors    = 0;
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function void write_width(logic [WIDTH_W-1:0] w);
      width_reg = w;
    endfunction

    // Append the low width bits of one request, MSB first, and queue full bytes
    function void note_request(logic [VALUE_W-1:0] value, logic last);
      int unsigned        bits;
      int unsigned        fb;
      int unsigned        made;
      logic [VALUE_W-1:0] v;
      logic [VALUE_W-1:0] chunk;
      packed_byte_t       pb;
      bits = width_reg;
      if (bits < 1) bits = 1;
      if (bits > 64) bits = 64;
      fb = free_cnt;
      if (fb < 1 || fb > 8) fb = 8;
      made = 0;
      v = value;
      if (bits < 64) v = v & ((64'd1 << bits) - 64'd1);
      while (bits >= fb) begin
        chunk = (v >> (bits - fb)) & ((64'd1 << fb) - 64'd1);
        partial = partial | chunk[BYTE_W-1:0];
        pb.data = partial;
        pb.last = 1'b0;
        pending.push_back(pb);
        made++;
        bits = bits - fb;
        fb = 8;
        partial = '0;
      end
      if (bits > 0) begin
        chunk = (v & ((64'd1 << bits) - 64'd1)) << (fb - bits);
        partial = partial | chunk[BYTE_W-1:0];
        fb = fb - bits;
      end
      // Flush a partly filled byte and flag the final byte of the list
      if (last) begin
        if (fb != 8) begin
          pb.data = partial;
          pb.last = 1'b0;
          pending.push_back(pb);
          made++;
        end
        partial = '0;
        fb = 8;
        if (made > 0) pending[pending.size()-1].last = 1'b1;
      end
      free_cnt = fb[FREE_W-1:0];
    endfunction

    task check_byte(logic [BYTE_W-1:0] data, logic last);
      packed_byte_t exp_b;
      if (pending.size() == 0) begin
        report($sformatf("byte 0x%02h last %0b with nothing expected", data, last));
        return;
      end
      exp_b = pending.pop_front();
      if (data !== exp_b.data)
        report($sformatf("out_tdata 0x%02h, expected 0x%02h", data, exp_b.data));
      if (last !== exp_b.last)
        report($sformatf("out_tlast %0b, expected %0b", last, exp_b.last));
    endtask

    task final_check();
      if (pending.size() != 0)
        report($sformatf("%0d expected bytes never arrived", pending.size()));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [6:0]         cfg_wr_data = '0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [63:0]        in_tdata = '0;
  logic               in_tlast = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [7:0]         out_tdata;
  logic               out_tlast;

  packer_scoreboard   sb = new();
  int unsigned        cycles = 0;
  int unsigned        hold_requests = 0;

  msb_first_bit_packer_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Check bytes at the falling edge; they are taken at the next rising edge
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_byte(out_tdata, out_tlast);
  end

  // Receiver: stretches of different stall patterns, plus long hold-offs on demand
  initial begin : receiver
    int unsigned mode;
    int unsigned stretch;
    int unsigned k;
    int unsigned cnt;
    int unsigned holds_served;
    logic        rdy;
    holds_served = 0;
    forever begin
      mode    = $urandom_range(0, 3);
      stretch = $urandom_range(1, 64);
      k       = $urandom_range(2, 5);
      for (cnt = 0; cnt < stretch; cnt++) begin
        @(posedge clk);
        if (holds_served != hold_requests) begin
          holds_served = hold_requests;
          out_tready <= 1'b0;
          repeat (LONG_HOLD - 1) @(posedge clk);
        end else begin
          case (mode)
            0: begin
              rdy = 1'b1;
            end
            1: begin
              rdy = 1'($urandom_range(0, 1));
            end
            2: begin
              rdy = (cnt % k) == 0;
            end
            default: begin
              rdy = $urandom_range(0, 7) != 0;
            end
          endcase
          out_tready <= rdy;
        end
      end
    end
  end

  // Offer one request and hold it until taken; return at the accepting edge
  task automatic send(input logic [63:0] value, input logic last);
    logic ok;
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= last;
    do begin
      @(negedge clk);
      ok = in_tready;
      @(posedge clk);
    end while (!ok);
    sb.note_request(value, last);
  endtask

  task automatic idle(input int unsigned n);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drop valid, wait for every expected byte, then let the block settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_width(input logic [6:0] w);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.write_width(w);
  endtask

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [6:0] pick_width(input int unsigned phase);
    case (phase)
      0: return 7'd1;
      1: return 7'd64;
      2: return 7'd127;
      3: return 7'd0;
      default: begin
        case ($urandom_range(0, 5))
          0: return 7'd8;
          1: return 7'(7 + $urandom_range(0, 2));
          2: return 7'(63 + $urandom_range(0, 2));
          3: return 7'($urandom_range(0, 127));
          default: return 7'($urandom_range(1, 64));
        endcase
      end
    endcase
  endfunction

  // Random lists of requests in bursts with gaps, under several widths
  task automatic random_phase(input int unsigned phase);
    int unsigned left;
    int unsigned burst;
    int unsigned i;
    set_width(pick_width(phase));
    // Fill the block while the receiver holds off
    if (phase == 1) hold_requests++;
    left = PHASE_ITEMS;
    while (left > 0) begin
      burst = $urandom_range(1, 16);
      for (i = 0; i < burst && left > 0; i++) begin
        send(pick_value(), $urandom_range(0, 7) == 0);
        left--;
      end
      if ($urandom_range(0, 39) == 0) drain();
      else idle($urandom_range(0, 12));
    end
  endtask

  initial begin : main
    int unsigned phase;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset width of 8: extremes, an aligned end, upper bits to be dropped
    send(64'h0, 1'b0);
    send(64'hFF, 1'b0);
    send(64'hA5, 1'b1);
    send(64'hFFFF_FFFF_FFFF_FF3C, 1'b0);
    send(64'h01, 1'b1);

    // One pending bit, then a full 64-bit last request: nine bytes
    set_width(7'd1);
    send(64'h1, 1'b0);
    set_width(7'd64);
    send('1, 1'b1);
    send(64'h0, 1'b1);
    send(64'h8000_0000_0000_0001, 1'b0);

    // Width zero acts as one
    set_width(7'd0);
    send(64'h1, 1'b0);
    send(64'h0, 1'b0);
    send('1, 1'b1);

    // Widths above range act as 64
    set_width(7'd127);
    send(64'h0123_4567_89AB_CDEF, 1'b1);
    set_width(7'd65);
    send(64'hFEDC_BA98_7654_3210, 1'b0);
    send('1, 1'b1);

    // Odd widths straddle byte boundaries
    set_width(7'd3);
    send(64'h5, 1'b0);
    send(64'h2, 1'b0);
    send(64'h7, 1'b0);
    send(64'h1, 1'b0);
    send(64'h6, 1'b0);
    send(64'hFFFF_FFFF_FFFF_FFF3, 1'b1);
    set_width(7'd12);
    send(64'hABC, 1'b0);
    send(64'hFFF, 1'b0);
    send(64'h000, 1'b1);

    for (phase = 0; phase < PHASE_COUNT; phase++) random_phase(phase);

    drain();
    sb.final_check();
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
